// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sample on the rising clock edge and skip the check while rst_n is low.
`define LPBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Sample on the rising clock edge, through reset as well.
`define LPBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lpbs_pkg.sv =====
// Shared constants and register codes of the leaky peak bin selector.
package lpbs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_W      = 7;
  localparam int SCORE_W    = 16;
  localparam int SEL_BIN_W  = 6;

  localparam logic [LEN_W-1:0]   LEN_RST   = 7'd64;
  localparam logic [SCORE_W-1:0] DECAY_RST = 16'd64881;
  localparam logic [SCORE_W-1:0] INCR_RST  = 16'd410;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_LENGTH   = 2'd0,
    REG_DECAY_FACTOR    = 2'd1,
    REG_SCORE_INCREMENT = 2'd2
  } cfg_reg_t;

endpackage

// ===== hdl/leaky_peak_bin_selector.sv =====
// Leaky peak bin selector: takes one complex sample per clock, stores it in its bin,
// decays that bin's score in a score RAM, tracks the strongest bin and the top score as
// running maxima, and at the end of each vector raises the strongest bin's score and
// returns the stored sample of the higher-scoring of that bin and the top-score bin,
// with its index. Samples are taken at one per clock unless the input is held.
// The score RAM's read-modify-write path interlocks the input when an early sample
// of a new vector hits a bin whose score is still being written, or one of the two
// bins the previous vector's end is still deciding on. The last sample of a vector
// also waits while the previous vector's raised score has not reached the RAM or the
// output queue has no room for its result. A result is registered through stages 1
// to 4 after the last sample of its vector and waits in a two-entry output queue.
// After reset the score RAM is cleared one entry per clock with in_tready low;
// configuration writes are taken at any time.
module leaky_peak_bin_selector
  import lpbs_pkg::*;
#(
  parameter int MAX_BINS     = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: sample_re, sample_im
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,
  // out_tdata: selected_re, selected_im, selected_bin
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((2*SAMPLE_WIDTH+SEL_BIN_W+7)/8)*8-1:0] out_tdata,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]                      cfg_index,
  input  logic [CFG_DATA_W-1:0]                     cfg_data
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PW    = 2*SAMPLE_WIDTH;
  localparam int BW    = $clog2(MAX_BINS);
  localparam int LW    = (BW + 1 > LEN_W) ? BW + 1 : LEN_W;
  localparam int OUT_W = ((PW + SEL_BIN_W + 7)/8)*8;
  localparam int RES_W = PW + SEL_BIN_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_BINS);
  localparam logic [BW-1:0] LAST_BIN = BW'(MAX_BINS - 1);

  // Configuration registers
  logic [LEN_W-1:0]   vector_length_r;
  logic [SCORE_W-1:0] decay_factor_r;
  logic [SCORE_W-1:0] score_increment_r;

  // Control state
  logic          clearing_r;
  logic [BW-1:0] clr_idx_r;
  logic [BW-1:0] bin_position_r;

  // Stage 1: score read returns
  logic                 s1_valid_r;
  logic                 s1_last_r;
  logic [BW-1:0]        s1_pos_r;
  logic signed [SW-1:0] s1_re_r;
  logic signed [SW-1:0] s1_im_r;
  logic                 s1_ovr_r;
  logic [SCORE_W-1:0]   s1_ovr_val_r;

  // Stage 2: products ready, score written back, maxima updated
  logic                 s2_valid_r;
  logic                 s2_last_r;
  logic [BW-1:0]        s2_pos_r;
  logic [PW-1:0]        s2_sq_re_r;
  logic [PW-1:0]        s2_sq_im_r;
  logic [2*SCORE_W-1:0] s2_prod_r;

  // Running maxima
  logic [PW-1:0]      bp_power_r;
  logic [BW-1:0]      bp_bin_r;
  logic [SCORE_W-1:0] bp_score_r;
  logic [SCORE_W-1:0] top_score_r;
  logic [BW-1:0]      top_bin_r;

  // Stage 3: vector end, stage 4: sample read returns
  logic          s3_valid_r;
  logic          s4_valid_r;
  logic [BW-1:0] s4_bin_r;

  // Raised score not yet in the RAM
  logic               pend_valid_r;
  logic [BW-1:0]      pend_bin_r;
  logic [SCORE_W-1:0] pend_val_r;

  // Output queue
  logic [RES_W-1:0] q_data_r [2];
  logic             q_head_r;
  logic             q_tail_r;
  logic [1:0]       q_count_r;

  // RAM ports
  logic               score_we;
  logic [BW-1:0]      score_waddr;
  logic [SCORE_W-1:0] score_wdata;
  logic [SCORE_W-1:0] score_rdata;
  logic [PW-1:0]      sample_rdata;

  // Combinational signals
  logic [LW-1:0]        len_ext;
  logic [LW-1:0]        eff_len;
  logic                 in_last;
  logic                 end_busy;
  logic                 hazard;
  logic                 consume;
  logic                 last_block;
  logic                 in_fire;
  logic [SW-1:0]        in_re;
  logic [SW-1:0]        in_im;
  logic [SCORE_W-1:0]   s1_score;
  logic signed [PW-1:0] s1_re_ext;
  logic signed [PW-1:0] s1_im_ext;
  logic [PW-1:0]        s2_power;
  logic [SCORE_W-1:0]   s2_decayed;
  logic                 s2_first;
  logic [SCORE_W:0]     raised_sum;
  logic [SCORE_W-1:0]   raised;
  logic [BW-1:0]        win;
  logic                 flush;
  logic                 q_pop;

  assign in_re = in_tdata[SW-1:0];
  assign in_im = in_tdata[PW-1:SW];

  // Accept configuration writes at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r   <= LEN_RST;
      decay_factor_r    <= DECAY_RST;
      score_increment_r <= INCR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VECTOR_LENGTH:   vector_length_r   <= cfg_data[LEN_W-1:0];
        REG_DECAY_FACTOR:    decay_factor_r    <= cfg_data;
        REG_SCORE_INCREMENT: score_increment_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the vector length to 1..MAX_BINS and mark the last sample
  always_comb begin
    len_ext = LW'(vector_length_r);
    if (vector_length_r == '0) begin
      eff_len = LW'(1);
    end else if (len_ext > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = len_ext;
    end
    in_last = (LW'(bin_position_r) + LW'(1)) >= eff_len;
  end

  // Interlock: hold the input while its bin has a score or winner still in flight
  always_comb begin
    end_busy = (s1_valid_r && s1_last_r) || (s2_valid_r && s2_last_r) || s3_valid_r;
    hazard   = (s1_valid_r && s1_pos_r == bin_position_r) ||
               (s2_valid_r && s2_pos_r == bin_position_r) ||
               (end_busy && (bp_bin_r == bin_position_r || top_bin_r == bin_position_r));
    consume    = pend_valid_r && pend_bin_r == bin_position_r;
    last_block = in_last && ((pend_valid_r && !consume) || end_busy ||
                             (q_count_r + {1'b0, s4_valid_r}) >= 2'd2);
    in_tready  = !clearing_r && !hazard && !last_block;
    in_fire    = in_tvalid && in_tready;
  end

  // Clear the score RAM after reset and advance the bin position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r     <= 1'b1;
      clr_idx_r      <= '0;
      bin_position_r <= '0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + BW'(1);
        if (clr_idx_r == LAST_BIN) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_fire) begin
        bin_position_r <= in_last ? '0 : bin_position_r + BW'(1);
      end
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
    s1_last_r    <= in_last;
    s1_pos_r     <= bin_position_r;
    s1_re_r      <= in_re;
    s1_im_r      <= in_im;
    s1_ovr_r     <= consume;
    s1_ovr_val_r <= pend_val_r;
  end

  // Take the pending raised score in place of the stale RAM word
  always_comb begin
    s1_score  = s1_ovr_r ? s1_ovr_val_r : score_rdata;
    s1_re_ext = PW'(s1_re_r);
    s1_im_ext = PW'(s1_im_r);
  end

  // Stage 2 registers: squares and decay product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_last_r  <= s1_last_r;
    s2_pos_r   <= s1_pos_r;
    s2_sq_re_r <= unsigned'(s1_re_ext * s1_re_ext);
    s2_sq_im_r <= unsigned'(s1_im_ext * s1_im_ext);
    s2_prod_r  <= s1_score * decay_factor_r;
  end

  always_comb begin
    s2_power   = s2_sq_re_r + s2_sq_im_r;
    s2_decayed = s2_prod_r[2*SCORE_W-1:SCORE_W];
    s2_first   = s2_pos_r == '0;
  end

  // Update the strongest bin and the top score; a new vector restarts both
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_power_r  <= '0;
      bp_bin_r    <= '0;
      bp_score_r  <= '0;
      top_score_r <= '0;
      top_bin_r   <= '0;
    end else if (s2_valid_r) begin
      if (s2_first || s2_power > bp_power_r) begin
        bp_power_r <= s2_power;
        bp_bin_r   <= s2_pos_r;
        bp_score_r <= s2_decayed;
      end
      if (s2_first || s2_decayed > top_score_r) begin
        top_score_r <= s2_decayed;
        top_bin_r   <= s2_pos_r;
      end
    end
  end

  // Vector end: saturating raise and winner, lowest bin on ties
  always_comb begin
    raised_sum = {1'b0, bp_score_r} + {1'b0, score_increment_r};
    raised     = raised_sum[SCORE_W] ? '1 : raised_sum[SCORE_W-1:0];
    if (raised > top_score_r) begin
      win = bp_bin_r;
    end else if (raised == top_score_r) begin
      win = (bp_bin_r < top_bin_r) ? bp_bin_r : top_bin_r;
    end else begin
      win = top_bin_r;
    end
  end

  // Score RAM write port: clearing pass, then decayed scores, then pending raise
  always_comb begin
    flush       = 1'b0;
    score_we    = 1'b1;
    score_waddr = clr_idx_r;
    score_wdata = '0;
    if (clearing_r) begin
      score_waddr = clr_idx_r;
    end else if (s2_valid_r) begin
      score_waddr = s2_pos_r;
      score_wdata = s2_decayed;
    end else if (pend_valid_r) begin
      flush       = 1'b1;
      score_waddr = pend_bin_r;
      score_wdata = pend_val_r;
    end else begin
      score_we = 1'b0;
    end
  end

  // Hold the raised score until the next vector reads it or the port is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r   <= 1'b0;
      s4_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r && s2_last_r;
      s4_valid_r <= s3_valid_r;
      if (s3_valid_r) begin
        pend_valid_r <= 1'b1;
      end else if ((in_fire && consume) || flush) begin
        pend_valid_r <= 1'b0;
      end
    end
    if (s3_valid_r) begin
      pend_bin_r <= bp_bin_r;
      pend_val_r <= raised;
    end
    s4_bin_r <= win;
  end

  lpbs_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_BINS)
  ) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (score_waddr),
    .wdata (score_wdata),
    .raddr (bin_position_r),
    .rdata (score_rdata)
  );

  lpbs_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_BINS)
  ) u_sample_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (bin_position_r),
    .wdata ({in_im, in_re}),
    .raddr (win),
    .rdata (sample_rdata)
  );

  // Output queue: push the selected sample, pop on each out transaction
  assign q_pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r  <= 1'b0;
      q_tail_r  <= 1'b0;
      q_count_r <= '0;
    end else begin
      if (s4_valid_r) begin
        q_tail_r <= ~q_tail_r;
      end
      if (q_pop) begin
        q_head_r <= ~q_head_r;
      end
      q_count_r <= q_count_r + {1'b0, s4_valid_r} - {1'b0, q_pop};
    end
    if (s4_valid_r) begin
      q_data_r[q_tail_r] <= {SEL_BIN_W'(s4_bin_r), sample_rdata};
    end
  end

  assign out_tvalid = q_count_r != '0;
  assign out_tdata  = OUT_W'(q_data_r[q_head_r]);

endmodule

// ===== hdl/lpbs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lpbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first-come, read returns the old contents on a same-edge write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lpbs_checker.sv =====
// Port-level checker of the leaky peak bin selector and its bind.
`include "assert_macros.svh"

module lpbs_checker
  import lpbs_pkg::*;
#(
  parameter int MAX_BINS     = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  // out_tdata: selected_re, selected_im, selected_bin
  input logic [((2*SAMPLE_WIDTH+SEL_BIN_W+7)/8)*8-1:0] out_tdata
);

  localparam int PW = 2*SAMPLE_WIDTH;

  logic [SEL_BIN_W-1:0] sel_bin;
  logic                 in_xfer;

  assign sel_bin = out_tdata[PW+SEL_BIN_W-1:PW];
  assign in_xfer = in_tvalid && in_tready;

  // A stalled result holds its data
  `LPBS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // The score clearing pass blocks input right after reset
  `LPBS_ASSERT_ALWAYS(a_clear_blocks_input, !rst_n |=> !in_tready, "input taken during clearing pass")

  // The selected bin lies inside the store
  `LPBS_ASSERT(a_bin_range, out_tvalid |-> (int'(sel_bin) < MAX_BINS), "selected bin out of range")

  // An empty output queue fills only in answer to an earlier sample transaction
  `LPBS_ASSERT(a_result_latency, $rose(out_tvalid) |-> $past(in_xfer, 5), "result without matching sample")

endmodule

bind leaky_peak_bin_selector lpbs_checker #(
  .MAX_BINS     (MAX_BINS),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lpbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
